// ===== hw/rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared constants and types for the session table with TTL and LRU eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    localparam int ENTRIES = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int ID_W    = 128;
    localparam int TOK_W   = 256;
    localparam int STAMP_W = 32;

    localparam logic [31:0] TTL_RESET = 32'd300000;
    localparam logic [1:0]  ADDR_TTL  = 2'd0;

    typedef enum logic [2:0] {
        FN_LOGIN  = 3'd0,
        FN_CHECK  = 3'd1,
        FN_VERIFY = 3'd2,
        FN_LOGOUT = 3'd3,
        FN_TICK   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [4:0] cleared_count;
        logic       expired;
        logic       evicted;
        logic [3:0] slot;
        logic       found;
        logic       ok;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/session_table_ttl_lru_top.sv =====
// ----------------------------------------------------------------------------
// session_table_ttl_lru_top
// Session table: each request scans all entries through single-read-port memories,
// then commits one result and at most one entry update; a tick clears during the scan.
// ----------------------------------------------------------------------------
// A request runs from acceptance through the states SCAN, DRAIN and FINISH to
// the result register; the scan reads one table entry per cycle from the
// single read port of the id/token and stamp memories. One request is in flight
// at a time; a new request is accepted in the cycle after the previous one has
// reached the output register, even while that result waits for m_tready. FINISH
// holds while the output register is still full and its result is not taken.
// Valid bits live in flip-flops and are cleared at reset, so the table is
// usable in the first cycle after reset. ttl_ms sits at byte address 0.
`default_nettype none

module session_table_ttl_lru_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_ms[31:0], sid_hi[95:32], sid_lo[159:96], tok_w0[223:160],
    // tok_w1[287:224], tok_w2[351:288], tok_w3[415:352]
    input  wire logic [415:0] s_tdata,
    // func[2:0]
    input  wire logic [2:0]   s_tuser,
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // ok[0], found[1], slot[5:2], evicted[6], expired[7], cleared_count[12:8],
    // zero[15:13]
    output logic [15:0]       m_tdata,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import stl_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]         func_reg;
    logic [31:0]        now_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TOK_W-1:0]   tok_reg;

    logic [IDX_W-1:0]   rd_idx_reg;
    logic               ev_valid_reg;
    logic [IDX_W-1:0]   ev_idx_reg;

    logic [ID_W+TOK_W-1:0] idtok_mem [ENTRIES];
    logic [STAMP_W-1:0]    stamp_mem [ENTRIES];
    logic [ID_W+TOK_W-1:0] idtok_rd_reg;
    logic [STAMP_W-1:0]    stamp_rd_reg;

    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               hit_stale_reg;
    logic               hit_tok_eq_reg;
    logic [IDX_W-1:0]   min_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic [CNT_W-1:0]   clr_cnt_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        ttl_reg;

    logic               m_tvalid_reg;
    result_t            out_reg;

    logic               in_fire;
    logic               rd_en;
    logic               out_free;
    logic               finish_fire;
    logic               scan_last;

    logic               ev_hit;
    logic               ev_stale;
    logic               ev_tok_eq;
    logic [31:0]        ev_age;

    logic               free_any;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   login_idx;
    logic               is_login;
    logic               is_check;
    logic               is_logout;
    logic               is_tick;

    logic               id_we;
    logic               stamp_we;
    logic [IDX_W-1:0]   wr_idx;
    result_t            res_next;

    // ------------------------------------------------------------------
    // Handshake and sequencing
    // ------------------------------------------------------------------
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_last = (rd_idx_reg == IDX_W'(ENTRIES - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:   if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        rd_en       = 1'b0;
        finish_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:   rd_en = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: finish_fire = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ev_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ev_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            id_reg     <= s_tdata[159:32];
            tok_reg    <= {s_tdata[223:160], s_tdata[287:224],
                           s_tdata[351:288], s_tdata[415:352]};
            rd_idx_reg <= '0;
        end else if (rd_en && !scan_last) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
        if (rd_en) begin
            ev_idx_reg <= rd_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Entry memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (id_we) begin
            idtok_mem[wr_idx] <= {id_reg, tok_reg};
        end
        if (rd_en) begin
            idtok_rd_reg <= idtok_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[wr_idx] <= now_reg;
        end
        if (rd_en) begin
            stamp_rd_reg <= stamp_mem[rd_idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // Per-entry evaluation
    // ------------------------------------------------------------------
    assign ev_age    = now_reg - stamp_rd_reg;
    assign ev_stale  = !(ev_age < ttl_reg);
    assign ev_hit    = valid_reg[ev_idx_reg] && (idtok_rd_reg[ID_W+TOK_W-1:TOK_W] == id_reg);
    assign ev_tok_eq = (idtok_rd_reg[TOK_W-1:0] == tok_reg);

    assign is_login  = (func_reg == FN_LOGIN);
    assign is_check  = (func_reg == FN_CHECK);
    assign is_logout = (func_reg == FN_LOGOUT);
    assign is_tick   = (func_reg == FN_TICK);

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            found_reg <= 1'b0;
        end else if (ev_valid_reg) begin
            if (ev_hit && !found_reg) begin
                found_reg      <= 1'b1;
                hit_idx_reg    <= ev_idx_reg;
                hit_stale_reg  <= ev_stale;
                hit_tok_eq_reg <= ev_tok_eq;
            end
            if ((ev_idx_reg == '0) || (stamp_rd_reg < min_stamp_reg)) begin
                min_idx_reg   <= ev_idx_reg;
                min_stamp_reg <= stamp_rd_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Free slot search and commit
    // ------------------------------------------------------------------
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (!valid_reg[e]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(e);
            end
        end
    end

    assign login_idx = free_any ? free_idx : min_idx_reg;
    assign id_we     = finish_fire && is_login;
    assign stamp_we  = finish_fire && (is_login || (is_check && found_reg && !hit_stale_reg));
    assign wr_idx    = is_login ? login_idx : hit_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (in_fire) begin
                clr_cnt_reg <= '0;
            end else if (ev_valid_reg && is_tick && valid_reg[ev_idx_reg] && ev_stale) begin
                valid_reg[ev_idx_reg] <= 1'b0;
                clr_cnt_reg           <= clr_cnt_reg + CNT_W'(1);
            end
            if (finish_fire) begin
                if (is_login) begin
                    valid_reg[login_idx] <= 1'b1;
                end else if (found_reg && ((is_check && hit_stale_reg) || is_logout)) begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        res_next = '0;
        unique case (func_reg)
            FN_LOGIN: begin
                res_next.ok      = 1'b1;
                res_next.slot    = 4'(login_idx);
                res_next.evicted = !free_any;
            end
            FN_CHECK: begin
                res_next.found   = found_reg;
                res_next.slot    = found_reg ? 4'(hit_idx_reg) : 4'd0;
                res_next.ok      = found_reg && !hit_stale_reg;
                res_next.expired = found_reg && hit_stale_reg;
            end
            FN_VERIFY: begin
                res_next.found = found_reg;
                res_next.slot  = found_reg ? 4'(hit_idx_reg) : 4'd0;
                res_next.ok    = found_reg && hit_tok_eq_reg;
            end
            FN_LOGOUT: begin
                res_next.found = found_reg;
                res_next.slot  = found_reg ? 4'(hit_idx_reg) : 4'd0;
                res_next.ok    = found_reg;
            end
            FN_TICK: begin
                res_next.cleared_count = 5'(clr_cnt_reg);
                res_next.ok            = (clr_cnt_reg != '0);
            end
            default: res_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_fire) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg};

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg <= TTL_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_TTL)) begin
            ttl_reg <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_TTL) begin
            prdata = ttl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_SCAN) && (rd_idx_reg == '0))
        else $error("accepted transaction did not start a scan");

    a_finish_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        finish_fire |=> m_tvalid_reg && (state_reg == ST_IDLE))
        else $error("finished transaction did not reach the output register");

    a_clear_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_cnt_reg <= CNT_W'(ENTRIES))
        else $error("tick clear count exceeds table size");

    a_evict_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_fire && is_login && !free_any) |-> (valid_reg == '1))
        else $error("eviction with a free entry present");

    a_login_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_fire && is_login) |=> valid_reg[$past(login_idx)])
        else $error("login did not mark its entry valid");

endmodule

`default_nettype wire
